// ----- rtl/sidf_pkg.sv -----
// Shared widths, register codes, coefficient bundle and sequencer states for the stereo IIR.
package sidf_pkg;

	// Field widths
	localparam int SMP_W   = 16;
	localparam int COEF_W  = 18;
	localparam int DW_W    = 24;
	localparam int FRAC_SH = 16;

	// Radix-4 digits per coefficient, and the counter that walks them
	localparam int DIGITS    = COEF_W / 2;
	localparam int DIG_CNT_W = $clog2(DIGITS);

	// Accumulator: sum of a few 18x24 products plus the scaled sample
	localparam int ACC_W  = 44;
	localparam int PART_W = DW_W + 3;

	// Configuration port
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_FB_ONE  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FB_TWO  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FF_ZERO = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_FF_ONE  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_FF_TWO  = 3'd4;

	// Coefficient reset values (Q1.16)
	localparam logic [COEF_W-1:0] COEF_ZERO = '0;
	localparam logic [COEF_W-1:0] COEF_ONE  = COEF_W'(65536);

	// Rounding and saturation bounds at accumulator width
	localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(32768);
	localparam logic signed [ACC_W-1:0] DW_MAX_A   = ACC_W'(8388607);
	localparam logic signed [ACC_W-1:0] DW_MIN_A   = ACC_W'(-8388608);
	localparam logic signed [ACC_W-1:0] OUT_MAX_A  = ACC_W'(32767);
	localparam logic signed [ACC_W-1:0] OUT_MIN_A  = ACC_W'(-32768);

	typedef struct packed {
		logic [COEF_W-1:0] a1;
		logic [COEF_W-1:0] a2;
		logic [COEF_W-1:0] b0;
		logic [COEF_W-1:0] b1;
		logic [COEF_W-1:0] b2;
	} coef_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_FB,
		S_W0,
		S_FF,
		S_OUT
	} state_t;

endpackage

// ----- rtl/stereo_iir_direct_form_two.sv -----
// Stereo direct form II IIR filter top level: sequencer, delay words, rounding and saturation.
// Each word passes through idle, a 9-digit radix-4 multiply pass over the feedback and feedforward
// taps, a rounding state, the 9-digit b0 pass on the new delay word and a final rounding state that
// waits while an earlier result is pending; a new word is accepted only back in idle.
// The result register frees the input side while a finished word waits to be taken.
// Reset (arst_n low, asynchronous) clears delay words, restores b0 = 1.0, others zero.
module stereo_iir_direct_form_two #(
	parameter int ORDER = 1
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [sidf_pkg::SMP_W-1:0]          s_tdata,   // [15:0] sample_in
	input  logic                                s_tuser,   // [0] chan_sel
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [sidf_pkg::SMP_W-1:0]          m_tdata,   // [15:0] sample_out
	output logic                                m_tuser,   // [0] chan_out
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [sidf_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [sidf_pkg::COEF_W-1:0]         cfg_data
);

	sidf_pkg::coef_t  coef;
	sidf_pkg::state_t state_q, state_nx;

	logic [sidf_pkg::DIG_CNT_W-1:0]    dig_cnt_q;
	logic                              chan_q;
	logic signed [sidf_pkg::SMP_W-1:0] x_q;
	logic signed [sidf_pkg::DW_W-1:0]  w0_q;
	logic signed [sidf_pkg::DW_W-1:0]  dly_q [2][ORDER];
	logic                              m_tvalid_q;
	logic [sidf_pkg::SMP_W-1:0]        m_tdata_q;
	logic                              m_tuser_q;

	logic accept, lane_load, lane_step, b0_load, b0_step, out_load, last_digit;

	logic signed [sidf_pkg::ACC_W-1:0] fb_acc [ORDER];
	logic signed [sidf_pkg::ACC_W-1:0] ff_acc [ORDER];
	logic signed [sidf_pkg::ACC_W-1:0] b0_acc;
	logic [sidf_pkg::COEF_W-1:0]       fb_coef [ORDER];
	logic [sidf_pkg::COEF_W-1:0]       ff_coef [ORDER];

	logic signed [sidf_pkg::ACC_W-1:0] fb_sum, ff_sum, node_sum, node_shr, y_sum, y_shr;
	logic signed [sidf_pkg::ACC_W-1:0] x_ext;
	logic signed [sidf_pkg::DW_W-1:0]  w0_sat;
	logic [sidf_pkg::SMP_W-1:0]        y_sat;

	sidf_coef_regs u_coef (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.coef      (coef)
	);

	// One feedback lane and one feedforward lane per stored delay word
	for (genvar k = 0; k < ORDER; k++) begin : g_tap
		if (k == 0) begin : g_first
			assign fb_coef[k] = coef.a1;
			assign ff_coef[k] = coef.b1;
		end else begin : g_second
			assign fb_coef[k] = coef.a2;
			assign ff_coef[k] = coef.b2;
		end

		sidf_digit_mac u_fb (
			.clk    (clk),
			.arst_n (arst_n),
			.load   (lane_load),
			.step   (lane_step),
			.coef   (fb_coef[k]),
			.mult   (dly_q[chan_q][k]),
			.acc    (fb_acc[k])
		);

		sidf_digit_mac u_ff (
			.clk    (clk),
			.arst_n (arst_n),
			.load   (lane_load),
			.step   (lane_step),
			.coef   (ff_coef[k]),
			.mult   (dly_q[chan_q][k]),
			.acc    (ff_acc[k])
		);
	end

	// b0 lane runs on the fresh delay word
	sidf_digit_mac u_b0 (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (b0_load),
		.step   (b0_step),
		.coef   (coef.b0),
		.mult   (w0_q),
		.acc    (b0_acc)
	);

	assign last_digit = (dig_cnt_q == sidf_pkg::DIG_CNT_W'(sidf_pkg::DIGITS - 1));

	// Sequencer: next state and strobes
	always_comb begin
		state_nx  = state_q;
		s_tready  = 1'b0;
		lane_load = 1'b0;
		lane_step = 1'b0;
		b0_load   = 1'b0;
		b0_step   = 1'b0;
		out_load  = 1'b0;
		unique case (state_q)
			sidf_pkg::S_IDLE: begin
				s_tready  = 1'b1;
				lane_load = s_tvalid;
				if (s_tvalid) begin
					state_nx = sidf_pkg::S_FB;
				end
			end
			sidf_pkg::S_FB: begin
				lane_step = 1'b1;
				if (last_digit) begin
					state_nx = sidf_pkg::S_W0;
				end
			end
			sidf_pkg::S_W0: begin
				b0_load  = 1'b1;
				state_nx = sidf_pkg::S_FF;
			end
			sidf_pkg::S_FF: begin
				b0_step = 1'b1;
				if (last_digit) begin
					state_nx = sidf_pkg::S_OUT;
				end
			end
			sidf_pkg::S_OUT: begin
				if (!m_tvalid_q || m_tready) begin
					out_load = 1'b1;
					state_nx = sidf_pkg::S_IDLE;
				end
			end
			default: state_nx = sidf_pkg::S_IDLE;
		endcase
	end

	assign accept = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sidf_pkg::S_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	// Walk the digits during each multiply pass
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dig_cnt_q <= '0;
		end else if (lane_step || b0_step) begin
			dig_cnt_q <= last_digit ? '0 : dig_cnt_q + sidf_pkg::DIG_CNT_W'(1);
		end
	end

	// Hold the accepted word
	always_ff @(posedge clk) begin
		if (accept) begin
			x_q    <= $signed(s_tdata);
			chan_q <= s_tuser;
		end
	end

	// Feedback node: x*2^16 - sum a_k*w_k, round half up, saturate to 24 bits
	always_comb begin
		fb_sum = '0;
		ff_sum = '0;
		for (int k = 0; k < ORDER; k++) begin
			fb_sum = fb_sum + fb_acc[k];
			ff_sum = ff_sum + ff_acc[k];
		end
		x_ext = $signed({{(sidf_pkg::ACC_W-sidf_pkg::SMP_W-sidf_pkg::FRAC_SH){x_q[sidf_pkg::SMP_W-1]}},
			x_q, {sidf_pkg::FRAC_SH{1'b0}}});
		node_sum = x_ext + sidf_pkg::ROUND_HALF - fb_sum;
		node_shr = node_sum >>> sidf_pkg::FRAC_SH;
		if (node_shr > sidf_pkg::DW_MAX_A) begin
			w0_sat = sidf_pkg::DW_MAX_A[sidf_pkg::DW_W-1:0];
		end else if (node_shr < sidf_pkg::DW_MIN_A) begin
			w0_sat = sidf_pkg::DW_MIN_A[sidf_pkg::DW_W-1:0];
		end else begin
			w0_sat = node_shr[sidf_pkg::DW_W-1:0];
		end
	end

	// Output: b0*w0 + sum b_k*w_k, round half up, saturate to 16 bits
	always_comb begin
		y_sum = b0_acc + ff_sum + sidf_pkg::ROUND_HALF;
		y_shr = y_sum >>> sidf_pkg::FRAC_SH;
		if (y_shr > sidf_pkg::OUT_MAX_A) begin
			y_sat = sidf_pkg::OUT_MAX_A[sidf_pkg::SMP_W-1:0];
		end else if (y_shr < sidf_pkg::OUT_MIN_A) begin
			y_sat = sidf_pkg::OUT_MIN_A[sidf_pkg::SMP_W-1:0];
		end else begin
			y_sat = y_shr[sidf_pkg::SMP_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == sidf_pkg::S_W0) begin
			w0_q <= w0_sat;
		end
	end

	// Shift the selected channel's delay line once its old words are consumed
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < 2; c++) begin
				for (int k = 0; k < ORDER; k++) begin
					dly_q[c][k] <= '0;
				end
			end
		end else if (state_q == sidf_pkg::S_W0) begin
			for (int k = ORDER - 1; k > 0; k--) begin
				dly_q[chan_q][k] <= dly_q[chan_q][k-1];
			end
			dly_q[chan_q][0] <= w0_sat;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_tdata_q <= y_sat;
			m_tuser_q <= chan_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	// An accepted word keeps the input side closed on the next cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !s_tready)
		else $error("input side open right after accepting a word");

	// A result appears only from the final rounding step
	a_out_from_final: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(state_q) == sidf_pkg::S_OUT)
		else $error("result word raised outside the final step");

	// Channel tag holds through the b0 pass
	a_chan_stable: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == sidf_pkg::S_FF |-> $stable(chan_q))
		else $error("channel tag changed during the multiply pass");

	// A pending result is never overwritten
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> !m_tvalid_q || m_tready)
		else $error("result register overwritten while still pending");

endmodule

// ----- rtl/sidf_coef_regs.sv -----
// Coefficient register file written through the configuration channel.
module sidf_coef_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [sidf_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [sidf_pkg::COEF_W-1:0]    cfg_data,
	output sidf_pkg::coef_t               coef
);

	sidf_pkg::coef_t coef_q;

	// Always take a write; unknown indexes are dropped
	assign cfg_ready = 1'b1;
	assign coef      = coef_q;

	// Update the addressed coefficient
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q.a1 <= sidf_pkg::COEF_ZERO;
			coef_q.a2 <= sidf_pkg::COEF_ZERO;
			coef_q.b0 <= sidf_pkg::COEF_ONE;
			coef_q.b1 <= sidf_pkg::COEF_ZERO;
			coef_q.b2 <= sidf_pkg::COEF_ZERO;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				sidf_pkg::REG_FB_ONE:  coef_q.a1 <= cfg_data;
				sidf_pkg::REG_FB_TWO:  coef_q.a2 <= cfg_data;
				sidf_pkg::REG_FF_ZERO: coef_q.b0 <= cfg_data;
				sidf_pkg::REG_FF_ONE:  coef_q.b1 <= cfg_data;
				sidf_pkg::REG_FF_TWO:  coef_q.b2 <= cfg_data;
				default: ;
			endcase
		end
	end

endmodule

// ----- rtl/sidf_digit_mac.sv -----
// Radix-4 digit-serial multiplier: coefficient shifts out two bits a cycle while step is high, MSB first.
module sidf_digit_mac (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              load,
	input  logic                              step,
	input  logic [sidf_pkg::COEF_W-1:0]       coef,
	input  logic signed [sidf_pkg::DW_W-1:0]  mult,
	output logic signed [sidf_pkg::ACC_W-1:0] acc
);

	logic [sidf_pkg::COEF_W-1:0]       coef_q;
	logic                              first_q;
	logic signed [sidf_pkg::ACC_W-1:0] acc_q;
	logic signed [2:0]                 digit;
	logic signed [sidf_pkg::PART_W-1:0] part;
	logic signed [sidf_pkg::ACC_W-1:0] part_ext;

	// Top digit carries the sign weight, the rest are unsigned
	always_comb begin
		if (first_q) begin
			digit = $signed({coef_q[sidf_pkg::COEF_W-1], coef_q[sidf_pkg::COEF_W-1 -: 2]});
		end else begin
			digit = $signed({1'b0, coef_q[sidf_pkg::COEF_W-1 -: 2]});
		end
		part     = sidf_pkg::PART_W'(mult) * sidf_pkg::PART_W'(digit);
		part_ext = $signed({{(sidf_pkg::ACC_W-sidf_pkg::PART_W){part[sidf_pkg::PART_W-1]}}, part});
	end

	// Flag the sign digit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q <= 1'b0;
		end else if (load) begin
			first_q <= 1'b1;
		end else if (step) begin
			first_q <= 1'b0;
		end
	end

	// Horner step: scale the running sum by four and add the partial product
	always_ff @(posedge clk) begin
		if (load) begin
			coef_q <= coef;
			acc_q  <= '0;
		end else if (step) begin
			coef_q <= {coef_q[sidf_pkg::COEF_W-3:0], 2'b00};
			acc_q  <= (acc_q <<< 2) + part_ext;
		end
	end

	assign acc = acc_q;

endmodule
